// ----- rtl/bdsm_pkg.sv -----
package bdsm_pkg;

    // burst layout defaults
    localparam int TRAIN_SYMBOLS_DEF = 27;
    localparam int LINK_ID_BITS_DEF  = 32;

    // register widths
    localparam int TRAIN_W     = 27;
    localparam int LINK_W      = 32;
    localparam int TRAIN_EXT_W = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRAINING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ID  = 2'd1;

    localparam logic [TRAIN_W-1:0] TRAINING_RESET = 27'd132554954;
    localparam logic [LINK_W-1:0]  LINK_ID_RESET  = 32'd801918003;

    // symbol kinds
    localparam logic [1:0] KIND_TRAIN = 2'd0;
    localparam logic [1:0] KIND_LINK  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_CRC   = 2'd3;

    // crc-32/mpeg-2 and x^15+x^14+1 scrambler
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [14:0] SCR_SEED = 15'h0029;

    // item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic bit_first;
        logic bit_second;
        logic burst_start;
        logic burst_end;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // dibit to phase step in octants
    function automatic logic [2:0] phase_step(input logic b0, input logic b1);
        logic [2:0] step;
        unique case ({b0, b1})
            2'b00: step = 3'd1;
            2'b01: step = 3'd3;
            2'b11: step = 3'd5;
            2'b10: step = 3'd7;
        endcase
        return step;
    endfunction

    // one msb-first crc bit
    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic b);
        logic [31:0] shifted;
        shifted = {crc[30:0], 1'b0};
        return (crc[31] ^ b) ? (shifted ^ CRC_POLY) : shifted;
    endfunction

endpackage

// ----- rtl/burst_dqpsk_symbol_mapper_core.sv -----
// the first symbol of an item is registered in the queue and then in the output register
// one symbol per cycle unless the output stalls; a plain data item gives a single symbol
// a burst start adds TRAIN_SYMBOLS + LINK_ID_BITS/2 symbols, a burst end adds 16 crc symbols
// the symbol sequencer sets the rate, one symbol per cycle unless stalled; a 4-item queue decouples input
// reset (rst_n, async, low) empties the queue, zeroes the phase, seeds scrambler and crc,
// and loads the register reset values
module burst_dqpsk_symbol_mapper_core #(
    parameter int TRAIN_SYMBOLS = bdsm_pkg::TRAIN_SYMBOLS_DEF,
    parameter int LINK_ID_BITS  = bdsm_pkg::LINK_ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input item channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            bit_first,
    input  logic                            bit_second,
    input  logic                            burst_start,
    input  logic                            burst_end,
    // symbol channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      phase_octant,
    output logic [1:0]                      symbol_kind,
    output logic                            last_of_run,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [bdsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import bdsm_pkg::*;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    logic [TRAIN_W-1:0] training_word_reg;
    logic [LINK_W-1:0]  link_id_word_reg;

    // queue head handed from front to back, pop returned on the last symbol
    head_t head;
    logic  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            training_word_reg <= TRAINING_RESET;
            link_id_word_reg  <= LINK_ID_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TRAINING: training_word_reg <= cfg_wdata[TRAIN_W-1:0];
                CFG_LINK_ID:  link_id_word_reg  <= cfg_wdata[LINK_W-1:0];
                // writes beyond the register list are dropped
                default:      ;
            endcase
        end
    end

    // front: takes items into a small queue so input waits on a stalled output only once the queue is full
    bdsm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .bit_first   (bit_first),
        .bit_second  (bit_second),
        .burst_start (burst_start),
        .burst_end   (burst_end),
        .head        (head),
        .pop         (pop)
    );

    // back: sequences training, link id, data and crc symbols, one per cycle unless the output stalls,
    // into an output register that accepts a new symbol as the old one leaves
    bdsm_back #(
        .TRAIN_SYMBOLS (TRAIN_SYMBOLS),
        .LINK_ID_BITS  (LINK_ID_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .training_word (training_word_reg),
        .link_id_word  (link_id_word_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .phase_octant  (phase_octant),
        .symbol_kind   (symbol_kind),
        .last_of_run   (last_of_run)
    );

endmodule

// ----- rtl/bdsm_front.sv -----
module bdsm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            bit_first,
    input  logic            bit_second,
    input  logic            burst_start,
    input  logic            burst_end,
    output bdsm_pkg::head_t head,
    input  logic            pop
);
    import bdsm_pkg::*;

    localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW+1)'(QUEUE_DEPTH);

    item_t                q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 push;
    item_t                in_item;

    always_comb
    begin
        in_ready             = (count_reg != FULL_COUNT);
        push                 = in_valid && in_ready;
        in_item.bit_first    = bit_first;
        in_item.bit_second   = bit_second;
        in_item.burst_start  = burst_start;
        in_item.burst_end    = burst_end;
        head.valid           = (count_reg != '0);
        head.item            = q_mem[rd_ptr_reg];
        count_next           = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/bdsm_back.sv -----
module bdsm_back #(
    parameter int TRAIN_SYMBOLS = bdsm_pkg::TRAIN_SYMBOLS_DEF,
    parameter int LINK_ID_BITS  = bdsm_pkg::LINK_ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bdsm_pkg::head_t              head,
    output logic                         pop,
    input  logic [bdsm_pkg::TRAIN_W-1:0] training_word,
    input  logic [bdsm_pkg::LINK_W-1:0]  link_id_word,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [2:0]                   phase_octant,
    output logic [1:0]                   symbol_kind,
    output logic                         last_of_run
);
    import bdsm_pkg::*;

    localparam logic [2:0] ST_HEAD  = 3'd0;
    localparam logic [2:0] ST_TRAIN = 3'd1;
    localparam logic [2:0] ST_LINK  = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_CRC   = 3'd4;

    localparam logic [4:0] TRAIN_LAST = 5'(TRAIN_SYMBOLS - 1);
    localparam logic [4:0] LINK_TOP   = 5'(LINK_ID_BITS - 1);
    localparam logic [4:0] LINK_LAST  = 5'(LINK_ID_BITS / 2 - 1);
    localparam logic [4:0] CRC_LAST   = 5'd15;

    logic [2:0]  st_reg, st_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [2:0]  phase_reg, phase_next;
    logic [14:0] scr_reg, scr_next;
    logic [31:0] crc_reg, crc_next;

    logic        out_valid_reg;
    logic [2:0]  phase_out_reg;
    logic [1:0]  kind_out_reg;
    logic        last_out_reg;

    logic                   fire;
    logic                   fresh;
    logic [4:0]             cnt_eff;
    logic [2:0]             base_phase;
    logic [14:0]            base_scr;
    logic [31:0]            base_crc;
    logic [1:0]             kind;
    logic [TRAIN_EXT_W-1:0] train_ext;
    logic [4:0]             tidx;
    logic [4:0]             lidx0;
    logic [4:0]             lidx1;
    logic                   fb1;
    logic                   fb2;
    logic [14:0]            scr_two;
    logic [31:0]            crc_data;
    logic                   cb0;
    logic                   cb1;
    logic                   s0;
    logic                   s1;
    logic                   is_last;

    always_comb
    begin
        fire       = head.valid && (!out_valid_reg || out_ready);
        fresh      = (st_reg == ST_HEAD) && head.item.burst_start;
        cnt_eff    = (st_reg == ST_HEAD) ? '0 : cnt_reg;
        base_phase = fresh ? 3'd0 : phase_reg;
        base_scr   = fresh ? SCR_SEED : scr_reg;
        base_crc   = fresh ? CRC_INIT : crc_reg;

        train_ext  = {{(TRAIN_EXT_W-TRAIN_W){1'b0}}, training_word};
        tidx       = TRAIN_LAST - cnt_eff;
        lidx0      = LINK_TOP - {cnt_eff[3:0], 1'b0};
        lidx1      = lidx0 - 5'd1;

        // two scrambler steps
        fb1        = base_scr[14] ^ base_scr[13];
        fb2        = base_scr[13] ^ base_scr[12];
        scr_two    = {base_scr[12:0], fb1, fb2};

        crc_data   = crc_step(crc_step(base_crc, head.item.bit_first), head.item.bit_second);
        cb0        = base_crc[{~cnt_eff[3:0], 1'b1}];
        cb1        = base_crc[{~cnt_eff[3:0], 1'b0}];

        unique case (st_reg)
            ST_HEAD:  kind = fresh ? KIND_TRAIN : KIND_DATA;
            ST_TRAIN: kind = KIND_TRAIN;
            ST_LINK:  kind = KIND_LINK;
            ST_DATA:  kind = KIND_DATA;
            ST_CRC:   kind = KIND_CRC;
            default:  kind = KIND_DATA;
        endcase

        s0       = 1'b0;
        s1       = 1'b0;
        scr_next = base_scr;
        crc_next = base_crc;
        st_next  = st_reg;
        cnt_next = cnt_eff;
        is_last  = 1'b0;

        unique case (kind)
            KIND_TRAIN:
            begin
                s0 = train_ext[tidx];
                s1 = train_ext[tidx];
                if (cnt_eff == TRAIN_LAST)
                begin
                    st_next  = ST_LINK;
                    cnt_next = '0;
                end
                else
                begin
                    st_next  = ST_TRAIN;
                    cnt_next = cnt_eff + 5'd1;
                end
            end
            KIND_LINK:
            begin
                s0 = link_id_word[lidx0];
                s1 = link_id_word[lidx1];
                if (cnt_eff == LINK_LAST)
                begin
                    st_next  = ST_DATA;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_eff + 5'd1;
                end
            end
            KIND_DATA:
            begin
                s0       = head.item.bit_first ^ fb1;
                s1       = head.item.bit_second ^ fb2;
                scr_next = scr_two;
                crc_next = crc_data;
                cnt_next = '0;
                if (head.item.burst_end)
                begin
                    st_next = ST_CRC;
                end
                else
                begin
                    st_next = ST_HEAD;
                    is_last = 1'b1;
                end
            end
            KIND_CRC:
            begin
                s0       = cb0 ^ fb1;
                s1       = cb1 ^ fb2;
                scr_next = scr_two;
                if (cnt_eff == CRC_LAST)
                begin
                    st_next  = ST_HEAD;
                    cnt_next = '0;
                    is_last  = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_eff + 5'd1;
                end
            end
        endcase

        phase_next = base_phase + phase_step(s0, s1);
        pop        = fire && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_HEAD;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            scr_reg       <= SCR_SEED;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                st_reg        <= st_next;
                cnt_reg       <= cnt_next;
                phase_reg     <= phase_next;
                scr_reg       <= scr_next;
                crc_reg       <= crc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            phase_out_reg <= phase_next;
            kind_out_reg  <= kind;
            last_out_reg  <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign phase_octant = phase_out_reg;
    assign symbol_kind  = kind_out_reg;
    assign last_of_run  = last_out_reg;

`ifndef SYNTHESIS
    a_crc_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && st_reg == ST_CRC && cnt_reg == CRC_LAST) |=> (st_reg == ST_HEAD))
        else $error("crc run did not return to item head");
    a_burst_opens_train: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && fresh) |=> (out_valid && symbol_kind == KIND_TRAIN && phase_reg != 3'd0
            || out_valid && symbol_kind == KIND_TRAIN))
        else $error("burst start did not open with training");
    a_plain_data_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && kind == KIND_DATA && !head.item.burst_end) |=> (out_valid && last_of_run))
        else $error("data item without end not flagged last");
`endif

endmodule
